FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the design; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock outside reset
`define SJF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define SJF_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SJF_ASSERT(label, clk, rst, prop, msg)
`define SJF_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: design/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths and controller/datapath interface types for the SJF scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

   localparam int IN_TIME_W  = 16;   // request time fields
   localparam int JOB_W      = 6;    // response job index
   localparam int OUT_TIME_W = 23;   // response time fields

   // controller -> datapath
   typedef struct packed {
      logic load;          // take the request on the input ports
      logic scan_restart;  // clear trackers, scan address back to zero
      logic scan_step;     // read one entry, advance scan address
      logic emit;          // finish the picked job, load response register
      logic jump;          // advance time to the earliest pending arrival
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;     // scan address is on the last stored job
      logic found;         // an arrived, unfinished job was picked
      logic set_done;      // the picked job is the last of the set
      logic out_free;      // response register can take a new result
   } status_type;

endpackage

FILE: design/sjf_nonpreemptive_scheduler.sv
// ----------------------------------------------------------------------------
// Each request is written to the store as it is taken; the final request
// starts scheduling. Each decision scans the N stored jobs through the store
// read port, drains the read pipe and decides; time jumping to a later arrival
// brings another such scan. A pick also waits on a stalled response register.
// Reset: synchronous, active high; clears control state, no clearing pass.
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler: loads a job set, then reports
// jobs in completion order with waiting and turnaround times.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sjf_nonpreemptive_scheduler #(
   parameter int MAX_JOBS  = 64,
   parameter int TIME_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sjf_pkg::IN_TIME_W-1:0]  req_arrival_time,
   input  logic [sjf_pkg::IN_TIME_W-1:0]  req_burst_time,
   input  logic                           req_final_job,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sjf_pkg::JOB_W-1:0]      rsp_job_index,
   output logic [sjf_pkg::OUT_TIME_W-1:0] rsp_waiting_time,
   output logic [sjf_pkg::OUT_TIME_W-1:0] rsp_turnaround_time,
   output logic                           rsp_jobs_dropped,
   output logic                           rsp_last_result
);
   import sjf_pkg::*;

   // Controller steps the scan; datapath holds the store, the pick trackers,
   // current time and the response register. A request is taken only while
   // the controller is loading. Requests beyond MAX_JOBS are discarded and
   // set the dropped flag carried on every response of the set.
   cmd_type    cmd;
   status_type status;

   sjf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_final_job (req_final_job),
      .status        (status),
      .cmd           (cmd),
      .req_stall     (req_stall)
   );

   sjf_dp #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_job_index       (rsp_job_index),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_jobs_dropped    (rsp_jobs_dropped),
      .rsp_last_result     (rsp_last_result)
   );

   // a job is only finished when picked and the response register is free
   `SJF_ASSERT(a_emit_ok, clock, reset, cmd.emit |-> (status.found && status.out_free), "bad emit")
   // a time jump never comes together with a pick
   `SJF_NEVER(a_jump_emit, clock, reset, cmd.jump && cmd.emit, "time jump together with a pick")
   // finishing the last job of a set reopens the request channel
   `SJF_ASSERT(a_set_end, clock, reset, (cmd.emit && status.set_done) |=> !req_stall, "no reopen")

endmodule

FILE: design/sjf_dp.sv
// ----------------------------------------------------------------------------
// sjf_dp
// Job store, scan trackers, time keeping and response register.
// ----------------------------------------------------------------------------
module sjf_dp #(
   parameter int MAX_JOBS  = 64,
   parameter int TIME_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sjf_pkg::cmd_type               cmd,
   output sjf_pkg::status_type            status,
   input  logic [sjf_pkg::IN_TIME_W-1:0]  req_arrival_time,
   input  logic [sjf_pkg::IN_TIME_W-1:0]  req_burst_time,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [sjf_pkg::JOB_W-1:0]      rsp_job_index,
   output logic [sjf_pkg::OUT_TIME_W-1:0] rsp_waiting_time,
   output logic [sjf_pkg::OUT_TIME_W-1:0] rsp_turnaround_time,
   output logic                           rsp_jobs_dropped,
   output logic                           rsp_last_result
);
   import sjf_pkg::*;

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int CUR_W = TIME_BITS + IDX_W + 1;   // holds max arrival plus all bursts

   // job store
   logic [TIME_BITS-1:0] arrival_mem [MAX_JOBS];
   logic [TIME_BITS-1:0] burst_mem   [MAX_JOBS];

   logic [CNT_W-1:0]     job_count_ff;
   logic [CNT_W-1:0]     finished_ff;
   logic                 overflow_ff;
   logic [MAX_JOBS-1:0]  done_ff;
   logic [CUR_W-1:0]     cur_ff;

   // scan pipeline
   logic [IDX_W-1:0]     scan_addr_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [TIME_BITS-1:0] rd_arr_ff;
   logic [TIME_BITS-1:0] rd_bur_ff;

   // trackers
   logic                 found_ff;
   logic [TIME_BITS-1:0] best_bur_ff;
   logic [TIME_BITS-1:0] best_arr_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic                 any_ff;
   logic [TIME_BITS-1:0] next_arr_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [JOB_W-1:0]      rsp_idx_ff;
   logic [OUT_TIME_W-1:0] rsp_wait_ff;
   logic [OUT_TIME_W-1:0] rsp_tat_ff;
   logic                  rsp_drop_ff;
   logic                  rsp_last_ff;

   logic             full;
   logic             wipe;
   logic             pending;
   logic             arrived;
   logic [CUR_W-1:0] wait_in;
   logic [CUR_W-1:0] tat_in;

   assign full    = (job_count_ff == CNT_W'(MAX_JOBS));
   assign pending = !done_ff[rd_idx_ff];
   assign arrived = (CUR_W'(rd_arr_ff) <= cur_ff);
   assign wait_in = cur_ff - CUR_W'(best_arr_ff);
   assign tat_in  = wait_in + CUR_W'(best_bur_ff);

   assign status.scan_last = (CNT_W'(scan_addr_ff) == job_count_ff - CNT_W'(1));
   assign status.found     = found_ff;
   assign status.set_done  = ((finished_ff + CNT_W'(1)) == job_count_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign wipe = cmd.emit && status.set_done;

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         arrival_mem[job_count_ff[IDX_W-1:0]] <= TIME_BITS'(req_arrival_time);
         burst_mem[job_count_ff[IDX_W-1:0]]   <= TIME_BITS'(req_burst_time);
      end
      rd_arr_ff <= arrival_mem[scan_addr_ff];
      rd_bur_ff <= burst_mem[scan_addr_ff];
      rd_idx_ff <= scan_addr_ff;
   end

   // set bookkeeping and time
   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= '0;
         overflow_ff  <= 1'b0;
         finished_ff  <= '0;
         done_ff      <= '0;
         cur_ff       <= '0;
      end else if (wipe) begin
         job_count_ff <= '0;
         overflow_ff  <= 1'b0;
         finished_ff  <= '0;
         done_ff      <= '0;
         cur_ff       <= '0;
      end else begin
         if (cmd.load) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               job_count_ff <= job_count_ff + CNT_W'(1);
            end
         end
         if (cmd.emit) begin
            finished_ff          <= finished_ff + CNT_W'(1);
            done_ff[best_idx_ff] <= 1'b1;
            cur_ff               <= cur_ff + CUR_W'(best_bur_ff);
         end else if (cmd.jump) begin
            cur_ff <= CUR_W'(next_arr_ff);
         end
      end
   end

   // scan address and read-valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         if (cmd.scan_restart) begin
            scan_addr_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_addr_ff <= scan_addr_ff + IDX_W'(1);
         end
      end
   end

   // shortest arrived burst (first index wins ties) and earliest pending arrival
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else if (cmd.scan_restart) begin
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else if (rd_vld_ff && pending) begin
         if (arrived && (!found_ff || rd_bur_ff < best_bur_ff)) begin
            found_ff    <= 1'b1;
            best_bur_ff <= rd_bur_ff;
            best_arr_ff <= rd_arr_ff;
            best_idx_ff <= rd_idx_ff;
         end
         if (!any_ff || rd_arr_ff < next_arr_ff) begin
            any_ff      <= 1'b1;
            next_arr_ff <= rd_arr_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_idx_ff  <= JOB_W'(best_idx_ff);
         rsp_wait_ff <= OUT_TIME_W'(wait_in);
         rsp_tat_ff  <= OUT_TIME_W'(tat_in);
         rsp_drop_ff <= overflow_ff;
         rsp_last_ff <= status.set_done;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_job_index       = rsp_idx_ff;
   assign rsp_waiting_time    = rsp_wait_ff;
   assign rsp_turnaround_time = rsp_tat_ff;
   assign rsp_jobs_dropped    = rsp_drop_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule

FILE: design/sjf_ctrl.sv
// ----------------------------------------------------------------------------
// sjf_ctrl
// Sequencer: load, scan the store, drain the read pipe, then pick or jump.
// ----------------------------------------------------------------------------
module sjf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_final_job,
   input  sjf_pkg::status_type status,
   output sjf_pkg::cmd_type    cmd,
   output logic                req_stall
);
   import sjf_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_LOAD);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final_job) begin
                  cmd.scan_restart = 1'b1;
                  state_in         = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.found) begin
               // nothing has arrived: move time on and rescan
               cmd.jump         = 1'b1;
               cmd.scan_restart = 1'b1;
               state_in         = ST_SCAN;
            end else if (status.out_free) begin
               cmd.emit         = 1'b1;
               cmd.scan_restart = 1'b1;
               state_in         = status.set_done ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
